// ----- src/svsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package svsb_pkg;

  localparam int unsigned MaxFacesDef = 4096;
  localparam int unsigned FaceIdW     = 12;
  localparam int unsigned OtherW      = 13;
  localparam int unsigned InIdxW      = 16;
  localparam int unsigned OutIdxW     = 17;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InDataW     = 272;
  localparam int unsigned OutDataW    = 72;

  typedef enum logic {
    OP_FACE = 1'b0,
    OP_EDGE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_LIGHT_CAP = 2'd0,
    KIND_DARK_CAP  = 2'd1,
    KIND_QUAD      = 2'd2
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_LIGHT_X      = 3'd0,
    CFG_LIGHT_Y      = 3'd1,
    CFG_LIGHT_Z      = 3'd2,
    CFG_VERTEX_COUNT = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e                      op;
    logic [FaceIdW-1:0]       face_id;
    logic signed [OtherW-1:0] other_face;
    logic [InIdxW-1:0]        index_a;
    logic [InIdxW-1:0]        index_b;
    logic [InIdxW-1:0]        index_c;
  } item_t;

  // Item plus the range checks of its two face numbers against the flag store.
  typedef struct packed {
    item_t it;
    logic  fid_ok;
    logic  oth_ok;
  } stage_t;

  // Load strobes of the three arithmetic stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ld_t;

endpackage

`default_nettype wire

// ----- src/svsb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module svsb_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr0_i,
  input  wire logic [AW-1:0]    raddr1_i,
  output logic      [WIDTH-1:0] rdata0_o,
  output logic      [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/svsb_dot.sv -----
`timescale 1ns / 1ps
`default_nettype none

module svsb_dot import svsb_pkg::*; (
  input  wire logic                     clk_i,
  input  wire pipe_ld_t                 ld_i,
  input  wire logic signed [CoordW-1:0] vert_x_i,
  input  wire logic signed [CoordW-1:0] vert_y_i,
  input  wire logic signed [CoordW-1:0] vert_z_i,
  input  wire logic signed [CoordW-1:0] norm_x_i,
  input  wire logic signed [CoordW-1:0] norm_y_i,
  input  wire logic signed [CoordW-1:0] norm_z_i,
  input  wire logic signed [CoordW-1:0] light_x_i,
  input  wire logic signed [CoordW-1:0] light_y_i,
  input  wire logic signed [CoordW-1:0] light_z_i,
  output logic                          lit_o
);

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = DiffW + CoordW;
  localparam int unsigned SumW  = ProdW + 2;

  logic signed [DiffW-1:0]  dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  logic signed [CoordW-1:0] nx_q, ny_q, nz_q;
  logic signed [ProdW-1:0]  px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic signed [SumW-1:0]   sum_d;
  logic                     lit_q;

  // Differences are exact in one extra bit.
  assign dx_d = DiffW'(vert_x_i) - DiffW'(light_x_i);
  assign dy_d = DiffW'(vert_y_i) - DiffW'(light_y_i);
  assign dz_d = DiffW'(vert_z_i) - DiffW'(light_z_i);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
      nx_q <= norm_x_i;
      ny_q <= norm_y_i;
      nz_q <= norm_z_i;
    end
  end

  assign px_d = dx_q * nx_q;
  assign py_d = dy_q * ny_q;
  assign pz_d = dz_q * nz_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld2) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  // Two guard bits keep the sum of three products exact, so the sign is exact.
  assign sum_d = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      lit_q <= sum_d[SumW-1];
    end
  end

  assign lit_o = lit_q;

endmodule

`default_nettype wire

// ----- src/svsb_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module svsb_emit import svsb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire stage_t               st_i,
  input  wire logic                 lit_i,
  input  wire logic                 front_raw_i,
  input  wire logic                 back_raw_i,
  input  wire logic [OutIdxW-1:0]   vertex_count_i,
  output logic                      ready_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output kind_e                     kind_o,
  output logic [3:0][OutIdxW-1:0]   index_o
);

  logic                      out_valid_q;
  kind_e                     kind_d, kind_q;
  logic [3:0][OutIdxW-1:0]   index_d, index_q;
  logic [OutIdxW-1:0]        a_ext, b_ext, c_ext, a_off, b_off, c_off;
  logic                      front, back, has_result;

  assign a_ext = {1'b0, st_i.it.index_a};
  assign b_ext = {1'b0, st_i.it.index_b};
  assign c_ext = {1'b0, st_i.it.index_c};
  assign a_off = a_ext + vertex_count_i;
  assign b_off = b_ext + vertex_count_i;
  assign c_off = c_ext + vertex_count_i;

  // Faces outside the flag store read as lit; an edge with no back face
  // always counts as a silhouette edge.
  assign front = st_i.fid_ok & front_raw_i;
  assign back  = st_i.it.other_face[OtherW-1] ? ~front : (st_i.oth_ok & back_raw_i);

  always_comb begin
    kind_d     = KIND_QUAD;
    index_d    = '0;
    has_result = 1'b1;
    case (st_i.it.op)
      OP_FACE: begin
        if (lit_i) begin
          kind_d  = KIND_LIGHT_CAP;
          index_d = {{OutIdxW{1'b0}}, c_ext, b_ext, a_ext};
        end else begin
          kind_d  = KIND_DARK_CAP;
          index_d = {{OutIdxW{1'b0}}, c_off, b_off, a_off};
        end
      end
      OP_EDGE: begin
        has_result = front ^ back;
        if (front) begin
          index_d = {a_off, b_off, b_ext, a_ext};
        end else begin
          index_d = {b_off, a_off, a_ext, b_ext};
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  assign ready_o = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i & has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      kind_q  <= kind_d;
      index_q <= index_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign index_o     = index_q;

endmodule

`default_nettype wire

// ----- src/shadow_volume_silhouette_builder_core.sv -----
// Items pass st1_q to st4_q and the output register. Throughput: one item per
// cycle unless the output stalls; the flag store takes one write or one pair of
// reads per cycle, and the multipliers sit in a stage of their own.
// Reset clears all stage valid bits, the output valid and the light and offset
// registers. The face flag store is not cleared; an entry is defined once written.
`timescale 1ns / 1ps
`default_nettype none

module shadow_volume_silhouette_builder_core import svsb_pkg::*; #(
  parameter int unsigned MAX_FACES = MaxFacesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // face_id, other_face, index_a, index_b, index_c, vert_x, vert_y, vert_z,
  // norm_x, norm_y, norm_z, zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // out_index0, out_index1, out_index2, out_index3, zero fill
  output logic [OutDataW-1:0]      m_axis_tdata,
  // kind
  output logic [1:0]               m_axis_tuser
);

  localparam int unsigned AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

  logic signed [CoordW-1:0] light_x_q, light_y_q, light_z_q;
  logic [OutIdxW-1:0]       vertex_count_q;

  logic                     v1_q, v2_q, v3_q, v4_q;
  stage_t                   st_in, st1_q, st2_q, st3_q, st4_q;
  logic                     en1, en2, en3, en4, en_out;
  pipe_ld_t                 ld;
  logic                     lit3, lit4_q;
  logic [OutIdxW-1:0]       fid_ext, oth_ext, wid_ext, rid0_ext, rid1_ext;
  logic                     ram_we, ram_re, ram_wdata, rd0, rd1;
  kind_e                    kind;
  logic [3:0][OutIdxW-1:0]  index;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q      <= '0;
      light_y_q      <= '0;
      light_z_q      <= '0;
      vertex_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_LIGHT_X:      light_x_q      <= cfg_data_i;
        CFG_LIGHT_Y:      light_y_q      <= cfg_data_i;
        CFG_LIGHT_Z:      light_z_q      <= cfg_data_i;
        CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[OutIdxW-1:0];
        default: ;
      endcase
    end
  end

  // Input unpacking and range checks
  assign st_in.it.op         = op_e'(s_axis_tuser);
  assign st_in.it.face_id    = s_axis_tdata[11:0];
  assign st_in.it.other_face = s_axis_tdata[24:12];
  assign st_in.it.index_a    = s_axis_tdata[40:25];
  assign st_in.it.index_b    = s_axis_tdata[56:41];
  assign st_in.it.index_c    = s_axis_tdata[72:57];

  assign fid_ext      = {{(OutIdxW-FaceIdW){1'b0}}, s_axis_tdata[11:0]};
  assign oth_ext      = {{(OutIdxW-FaceIdW){1'b0}}, s_axis_tdata[23:12]};
  assign st_in.fid_ok = fid_ext < OutIdxW'(MAX_FACES);
  assign st_in.oth_ok = oth_ext < OutIdxW'(MAX_FACES);

  // A stage takes a new item whenever it is empty or its item moves on.
  assign en4 = ~v4_q | en_out;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign s_axis_tready = en1;

  assign ld.ld1 = en1 & s_axis_tvalid;
  assign ld.ld2 = en2 & v1_q;
  assign ld.ld3 = en3 & v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld.ld1) st1_q <= st_in;
    if (ld.ld2) st2_q <= st1_q;
    if (ld.ld3) st3_q <= st2_q;
    if (en4 && v3_q) begin
      st4_q  <= st3_q;
      lit4_q <= lit3;
    end
  end

  svsb_dot u_dot (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .vert_x_i  (s_axis_tdata[104:73]),
    .vert_y_i  (s_axis_tdata[136:105]),
    .vert_z_i  (s_axis_tdata[168:137]),
    .norm_x_i  (s_axis_tdata[200:169]),
    .norm_y_i  (s_axis_tdata[232:201]),
    .norm_z_i  (s_axis_tdata[264:233]),
    .light_x_i (light_x_q),
    .light_y_i (light_y_q),
    .light_z_i (light_z_q),
    .lit_o     (lit3)
  );

  // Faces write and edges read as they leave the third stage, so each edge
  // sees the flags of every face that came before it.
  assign ram_we    = en4 & v3_q & (st3_q.it.op == OP_FACE) & st3_q.fid_ok;
  assign ram_re    = en4 & v3_q & (st3_q.it.op == OP_EDGE);
  assign ram_wdata = ~lit3;
  assign wid_ext   = {{(OutIdxW-FaceIdW){1'b0}}, st3_q.it.face_id};
  assign rid0_ext  = wid_ext;
  assign rid1_ext  = {{(OutIdxW-FaceIdW){1'b0}}, st3_q.it.other_face[FaceIdW-1:0]};

  svsb_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FACES)
  ) u_flags (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (wid_ext[AW-1:0]),
    .wdata_i  (ram_wdata),
    .re_i     (ram_re),
    .raddr0_i (rid0_ext[AW-1:0]),
    .raddr1_i (rid1_ext[AW-1:0]),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  svsb_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v4_q),
    .st_i           (st4_q),
    .lit_i          (lit4_q),
    .front_raw_i    (rd0),
    .back_raw_i     (rd1),
    .vertex_count_i (vertex_count_q),
    .ready_o        (en_out),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .kind_o         (kind),
    .index_o        (index)
  );

  assign m_axis_tdata = {(OutDataW - 4*OutIdxW)'(0), index};
  assign m_axis_tuser = kind;

  // A single item leaves the third stage per cycle: never a write and a read at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("flag store written and read in the same cycle");

  // Input backpressure only when every stage and the output register are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && m_axis_tvalid))
    else $error("input stalled while the pipeline has a bubble");

  // Every face yields a result on the next cycle once it reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en_out && st4_q.it.op == OP_FACE) |=> m_axis_tvalid)
    else $error("face item lost its result");

endmodule

`default_nettype wire
